// ===== src/lrs_pkg.sv =====
// lrs_pkg: shared types and constants for the largest remainder split block.
// No dependencies; used by src/largest_remainder_split.sv.
`timescale 1ns / 1ps

package lrs_pkg;

  // Weight registers and part slots
  localparam int unsigned WEIGHT_REGS = 4;
  localparam logic [16:0] WEIGHT_ONE  = 17'd65536;

  // Configuration register indexes
  localparam logic [2:0] CFG_PART_COUNT  = 3'd0;
  localparam logic [2:0] CFG_WEIGHT_ZERO = 3'd1;
  localparam logic [2:0] CFG_WEIGHT_ONE  = 3'd2;
  localparam logic [2:0] CFG_WEIGHT_TWO  = 3'd3;
  localparam logic [2:0] CFG_WEIGHT_THR  = 3'd4;

  // Reset values
  localparam logic [2:0]  PART_COUNT_RST = 3'd4;
  localparam logic [16:0] WEIGHT_RST     = 17'd16384;

  typedef logic [30:0] share_t;
  typedef logic [15:0] frac_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_LEFT,
    ST_PICK,
    ST_EMIT
  } state_t;

endpackage

// ===== src/largest_remainder_split.sv =====
// largest_remainder_split: top level, one shared multiplier and adder under a sequencer.
// Depends on src/lrs_pkg.sv (types, register indexes, state encoding).
`timescale 1ns / 1ps

// Splits one resource record among up to four parts by largest remainder on Q1.16
// weights. One record is handled at a time; in_stall is high from the accepting
// transfer until the last share has been handed to the output register. A record
// passes through the multiply steps on the single 31x17 multiplier, the steps
// accumulating the floor shares, the leftover step, the pick steps on the shared
// share adder and the steps scanning the parts for output, plus any output stall.
// Records with id 0, a quantity of zero or less, or no active part are accepted
// and give nothing. The output register lets the next record be accepted while the
// final share still waits for its transfer.
module largest_remainder_split #(
  parameter int NUM_PARTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_resource_id,
  input  logic signed [31:0] in_quantity,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_resource,
  output logic [1:0]         out_part_index,
  output logic [30:0]        out_share,
  output logic               out_last
);

  localparam int SLOTS = lrs_pkg::WEIGHT_REGS;
  // active part count is capped by the parameter and by the weight registers
  localparam int ACT_MAX = (NUM_PARTS < SLOTS) ? NUM_PARTS : SLOTS;
  localparam logic [2:0] ACT_MAX_C = 3'(ACT_MAX);

  // configuration
  logic [2:0]  part_count_r;
  logic [16:0] weight_r [SLOTS];

  // sequencer and datapath
  lrs_pkg::state_t state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [2:0]  n_r, n_nxt;
  logic [15:0] id_r, id_nxt;
  lrs_pkg::share_t q_r, q_nxt;
  lrs_pkg::share_t whole_r [SLOTS];
  lrs_pkg::share_t whole_nxt [SLOTS];
  lrs_pkg::frac_t  frac_r [SLOTS];
  lrs_pkg::frac_t  frac_nxt [SLOTS];
  logic [SLOTS-1:0] picked_r, picked_nxt;
  logic [32:0] alloc_r, alloc_nxt;
  lrs_pkg::share_t left_r, left_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_res_r, out_res_nxt;
  logic [1:0]  out_idx_r, out_idx_nxt;
  lrs_pkg::share_t out_share_r, out_share_nxt;
  logic        out_last_r, out_last_nxt;

  // helpers
  logic [2:0]  n_eff;
  logic        last_idx;
  logic        start;
  logic        in_xfer;
  logic [16:0] w_sel;
  logic [46:0] prod;
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] positive;
  logic [SLOTS-1:0] above;
  logic        found;
  logic [1:0]  best;
  lrs_pkg::frac_t best_frac;
  logic [1:0]  add_sel;
  lrs_pkg::share_t add_b;
  lrs_pkg::share_t add_sum;
  logic        slot_free;
  logic        emit_adv;
  logic        later_pos;
  logic [32:0] q_ext;

  assign n_eff    = (part_count_r > ACT_MAX_C) ? ACT_MAX_C : part_count_r;
  assign last_idx = ({1'b0, idx_r} == (n_r - 3'd1));
  assign in_stall = (state_r != lrs_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  // skipped records: no id, non-positive quantity, no active part
  assign start    = in_xfer && (in_resource_id != 16'd0) && !in_quantity[31]
                    && (in_quantity[30:0] != 31'd0) && (n_eff != 3'd0);

  // shared multiplier, weight saturated to one
  always_comb begin
    w_sel = weight_r[idx_r];
    if (w_sel > lrs_pkg::WEIGHT_ONE) begin
      w_sel = lrs_pkg::WEIGHT_ONE;
    end
  end
  // quantity below 2^31 times weight at most 2^16 fits in 47 bits
  assign prod = 47'(q_r) * 47'(w_sel);

  // part masks
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      active[i]   = (3'(i) < n_r);
      positive[i] = active[i] && (whole_r[i] != '0);
      above[i]    = (2'(i) > idx_r);
    end
  end
  assign later_pos = |(positive & above);

  // largest remainder among unpicked active parts; ties keep the lower index
  always_comb begin
    found     = 1'b0;
    best      = 2'd0;
    best_frac = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (active[i] && !picked_r[i] && (!found || frac_r[i] > best_frac)) begin
        found     = 1'b1;
        best      = 2'(i);
        best_frac = frac_r[i];
      end
    end
  end

  // shared share adder: one unit to the best part, or the whole rest to part 0
  assign add_sel = found ? best : 2'd0;
  assign add_b   = found ? 31'd1 : left_r;
  assign add_sum = whole_r[add_sel] + add_b;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit_adv  = !positive[idx_r] || slot_free;
  assign q_ext     = {2'b00, q_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrs_pkg::ST_IDLE: begin
        if (start) state_nxt = lrs_pkg::ST_MUL;
      end
      lrs_pkg::ST_MUL: begin
        if (last_idx) state_nxt = lrs_pkg::ST_SUM;
      end
      lrs_pkg::ST_SUM: begin
        if (last_idx) state_nxt = lrs_pkg::ST_LEFT;
      end
      lrs_pkg::ST_LEFT: begin
        state_nxt = lrs_pkg::ST_PICK;
      end
      lrs_pkg::ST_PICK: begin
        if (left_r == '0 || !found) state_nxt = lrs_pkg::ST_EMIT;
      end
      lrs_pkg::ST_EMIT: begin
        if (emit_adv && last_idx) state_nxt = lrs_pkg::ST_IDLE;
      end
      default: state_nxt = lrs_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    id_nxt        = id_r;
    q_nxt         = q_r;
    whole_nxt     = whole_r;
    frac_nxt      = frac_r;
    picked_nxt    = picked_r;
    alloc_nxt     = alloc_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    out_idx_nxt   = out_idx_r;
    out_share_nxt = out_share_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      lrs_pkg::ST_IDLE: begin
        if (start) begin
          idx_nxt    = 2'd0;
          n_nxt      = n_eff;
          id_nxt     = in_resource_id;
          q_nxt      = in_quantity[30:0];
          picked_nxt = '0;
          alloc_nxt  = '0;
        end
      end
      lrs_pkg::ST_MUL: begin
        whole_nxt[idx_r] = prod[46:16];
        frac_nxt[idx_r]  = prod[15:0];
        idx_nxt          = last_idx ? 2'd0 : idx_r + 2'd1;
      end
      lrs_pkg::ST_SUM: begin
        alloc_nxt = alloc_r + 33'(whole_r[idx_r]);
        idx_nxt   = last_idx ? 2'd0 : idx_r + 2'd1;
      end
      lrs_pkg::ST_LEFT: begin
        // floors above the quantity leave nothing to hand out
        left_nxt = (q_ext > alloc_r) ? 31'(q_ext - alloc_r) : '0;
      end
      lrs_pkg::ST_PICK: begin
        if (left_r != '0) begin
          whole_nxt[add_sel] = add_sum;
          if (found) begin
            picked_nxt[best] = 1'b1;
            left_nxt         = left_r - 31'd1;
          end else begin
            left_nxt = '0;
          end
        end
        idx_nxt = 2'd0;
      end
      lrs_pkg::ST_EMIT: begin
        if (positive[idx_r] && slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = id_r;
          out_idx_nxt   = idx_r;
          out_share_nxt = whole_r[idx_r];
          out_last_nxt  = !later_pos;
        end
        if (emit_adv) begin
          idx_nxt = last_idx ? 2'd0 : idx_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lrs_pkg::ST_IDLE;
      idx_r        <= 2'd0;
      n_r          <= 3'd0;
      picked_r     <= '0;
      out_valid_r  <= 1'b0;
      part_count_r <= lrs_pkg::PART_COUNT_RST;
      for (int i = 0; i < SLOTS; i++) begin
        weight_r[i] <= lrs_pkg::WEIGHT_RST;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      picked_r    <= picked_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          lrs_pkg::CFG_PART_COUNT:  part_count_r <= cfg_data[2:0];
          lrs_pkg::CFG_WEIGHT_ZERO: weight_r[0]  <= cfg_data;
          lrs_pkg::CFG_WEIGHT_ONE:  weight_r[1]  <= cfg_data;
          lrs_pkg::CFG_WEIGHT_TWO:  weight_r[2]  <= cfg_data;
          lrs_pkg::CFG_WEIGHT_THR:  weight_r[3]  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    q_r         <= q_nxt;
    whole_r     <= whole_nxt;
    frac_r      <= frac_nxt;
    alloc_r     <= alloc_nxt;
    left_r      <= left_nxt;
    out_res_r   <= out_res_nxt;
    out_idx_r   <= out_idx_nxt;
    out_share_r <= out_share_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_resource   = out_res_r;
  assign out_part_index = out_idx_r;
  assign out_share      = out_share_r;
  assign out_last       = out_last_r;

endmodule
